// File: rtl/gbn_pkg.sv
// Shared types and constants of the greedy box suppression block.
package gbn_pkg;

   localparam int unsigned CLASS_W = 8;
   localparam int unsigned SCORE_W = 16;
   localparam int unsigned EDGE_W  = 16;
   localparam int unsigned AREA_W  = 2 * EDGE_W;
   localparam int unsigned SC_W    = SCORE_W + CLASS_W;
   localparam int unsigned BOX_W   = 4 * EDGE_W;
   localparam int unsigned DATA_W  = SC_W + BOX_W;
   localparam int unsigned THR_W   = 16;
   localparam int unsigned QDEPTH  = 4;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_AGNOSTIC  = 1'b1;

   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   typedef struct packed {
      logic [BOX_W-1:0]   box;   // {bottom, right, top, left}
      logic [SC_W-1:0]    sc;    // {score, class}
      logic [AREA_W-1:0]  area;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic             agnostic;
   } cfg_type;

endpackage

// File: rtl/gbn_ram.sv
// Generic single write, single registered read RAM.
module gbn_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gbn_front.sv
// Input stage: takes detections and computes the box area.
module gbn_front
   import gbn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [87:0]     req_tdata,
   input  logic            req_tlast,
   output logic            q_valid,
   input  logic            q_ready,
   output entry_type       q_data
);

   logic [EDGE_W-1:0] left, top, right, bottom, dx, dy;
   logic              vld_ff;
   entry_type         ent_ff;

   assign left   = req_tdata[SC_W +: EDGE_W];
   assign top    = req_tdata[SC_W + EDGE_W +: EDGE_W];
   assign right  = req_tdata[SC_W + 2*EDGE_W +: EDGE_W];
   assign bottom = req_tdata[SC_W + 3*EDGE_W +: EDGE_W];
   assign dx = (right > left) ? right - left : '0;
   assign dy = (bottom > top) ? bottom - top : '0;

   assign req_tready = !vld_ff || q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         ent_ff.box  <= req_tdata[SC_W +: BOX_W];
         ent_ff.sc   <= {req_tdata[CLASS_W +: SCORE_W], req_tdata[0 +: CLASS_W]};
         ent_ff.area <= {{EDGE_W{1'b0}}, dx} * {{EDGE_W{1'b0}}, dy};
         ent_ff.last <= req_tlast;
      end
   end

   assign q_valid = vld_ff;
   assign q_data  = ent_ff;

endmodule

// File: rtl/gbn_queue.sv
// Short FIFO between the input stage and the suppression engine.
module gbn_queue
   import gbn_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data
);

   localparam int unsigned PW = $clog2(QDEPTH);

   entry_type       mem_ff [QDEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [PW:0]     cnt_ff;
   logic            push, pop;

   assign in_ready  = cnt_ff != (PW+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

endmodule

// File: rtl/gbn_back.sv
// Suppression engine: store, stable rank sort, greedy IoU suppression, output.
module gbn_back
   import gbn_pkg::*;
#(
   parameter int unsigned MAX_DETECTIONS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  entry_type           q_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   localparam int unsigned IW = $clog2(MAX_DETECTIONS);
   localparam logic [IW:0] MAXN = (IW+1)'(MAX_DETECTIONS);

   typedef enum logic [3:0] {
      LOAD, RK_I, RK_IW, RK_SCAN, N_I, N_IO, N_ID, N_PUSH, N_SCAN, N_END
   } state_type;

   state_type state_ff;

   logic [IW:0]  cnt_ff, i_ff, j_ff, rank_ff;
   logic         ovf_ff;
   logic [SCORE_W-1:0] si_ff;
   logic [MAX_DETECTIONS-1:0] sup_ff;

   logic         v1_ff;
   logic [IW:0]  jp_ff;

   logic [BOX_W-1:0]  a_box_ff;
   logic [SC_W-1:0]   a_sc_ff;
   logic [AREA_W-1:0] a_area_ff;

   logic [DATA_W-1:0] pend_ff;
   logic              pend_vld_ff;
   logic [DATA_W-1:0] out_ff;
   logic              out_vld_ff, out_last_ff, out_ovf_ff;

   // suppression pipeline
   logic              p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [IW-1:0]     x0_ff, x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   logic [EDGE_W-1:0] dx_ff, dy_ff;
   logic              ok2_ff, ok3_ff, ok4_ff, ok5_ff;
   logic [AREA_W-1:0] ab2_ff, ab3_ff, in3_ff, in4_ff, in5_ff;
   logic [AREA_W:0]   uni_ff;
   logic [AREA_W+THR_W:0] prod_ff;

   // memory ports
   logic              st_we, dr_en, or_en, or_we;
   logic [IW-1:0]     dr_addr, or_addr;
   logic [BOX_W-1:0]  box_rd;
   logic [SC_W-1:0]   sc_rd;
   logic [AREA_W-1:0] area_rd;
   logic [IW-1:0]     or_rd;

   logic out_free, out_load, rk_done, sc_done, issue_j;
   logic [EDGE_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, x1, y1, x2, y2;

   assign out_free = !out_vld_ff || rsp_tready;
   assign out_load = (state_ff == N_PUSH && pend_vld_ff && out_free) ||
                     (state_ff == N_END && out_free);
   assign issue_j  = j_ff < cnt_ff;
   assign rk_done  = !issue_j && !v1_ff;
   assign sc_done  = !issue_j && !(p0_ff || p1_ff || p2_ff || p3_ff || p4_ff || p5_ff);
   assign q_ready  = state_ff == LOAD;
   assign st_we    = q_valid && q_ready && (cnt_ff < MAXN);
   assign or_we    = state_ff == RK_SCAN && rk_done;

   always_comb begin
      dr_en   = 1'b0;
      dr_addr = '0;
      or_en   = 1'b0;
      or_addr = '0;
      case (state_ff)
         RK_I: begin
            dr_en   = 1'b1;
            dr_addr = i_ff[IW-1:0];
         end
         RK_SCAN: begin
            dr_en   = issue_j;
            dr_addr = j_ff[IW-1:0];
         end
         N_I: begin
            or_en   = 1'b1;
            or_addr = i_ff[IW-1:0];
         end
         N_IO: begin
            dr_en   = 1'b1;
            dr_addr = or_rd;
         end
         N_SCAN: begin
            or_en   = issue_j;
            or_addr = j_ff[IW-1:0];
            dr_en   = p0_ff;
            dr_addr = or_rd;
         end
         default: ;
      endcase
   end

   gbn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_DETECTIONS)) u_box (
      .clock, .wr_en(st_we), .wr_addr(cnt_ff[IW-1:0]), .wr_data(q_data.box),
      .rd_en(dr_en), .rd_addr(dr_addr), .rd_data(box_rd));
   gbn_ram #(.WIDTH(SC_W), .DEPTH(MAX_DETECTIONS)) u_sc (
      .clock, .wr_en(st_we), .wr_addr(cnt_ff[IW-1:0]), .wr_data(q_data.sc),
      .rd_en(dr_en), .rd_addr(dr_addr), .rd_data(sc_rd));
   gbn_ram #(.WIDTH(AREA_W), .DEPTH(MAX_DETECTIONS)) u_area (
      .clock, .wr_en(st_we), .wr_addr(cnt_ff[IW-1:0]), .wr_data(q_data.area),
      .rd_en(dr_en), .rd_addr(dr_addr), .rd_data(area_rd));
   gbn_ram #(.WIDTH(IW), .DEPTH(MAX_DETECTIONS)) u_order (
      .clock, .wr_en(or_we), .wr_addr(rank_ff[IW-1:0]), .wr_data(i_ff[IW-1:0]),
      .rd_en(or_en), .rd_addr(or_addr), .rd_data(or_rd));

   // box geometry of the kept entry against the scanned one
   assign {ay2, ax2, ay1, ax1} = a_box_ff;
   assign {by2, bx2, by1, bx1} = box_rd;
   assign x1 = (ax1 > bx1) ? ax1 : bx1;
   assign y1 = (ay1 > by1) ? ay1 : by1;
   assign x2 = (ax2 < bx2) ? ax2 : bx2;
   assign y2 = (ay2 < by2) ? ay2 : by2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LOAD;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         v1_ff       <= 1'b0;
         {p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff} <= '0;
         sup_ff      <= '0;
      end else begin
         if (out_vld_ff && rsp_tready && !out_load) out_vld_ff <= 1'b0;

         // pipeline advance (only active in N_SCAN)
         p0_ff <= state_ff == N_SCAN && issue_j;
         x0_ff <= j_ff[IW-1:0];
         p1_ff <= p0_ff;
         x1_ff <= x0_ff;
         p2_ff <= p1_ff;
         x2_ff <= x1_ff;
         dx_ff <= x2 - x1;
         dy_ff <= y2 - y1;
         ok2_ff <= (x2 > x1) && (y2 > y1) &&
                   (cfg.agnostic || a_sc_ff[CLASS_W-1:0] == sc_rd[CLASS_W-1:0]);
         ab2_ff <= area_rd;
         p3_ff <= p2_ff;
         x3_ff <= x2_ff;
         ok3_ff <= ok2_ff;
         ab3_ff <= ab2_ff;
         in3_ff <= {{EDGE_W{1'b0}}, dx_ff} * {{EDGE_W{1'b0}}, dy_ff};
         p4_ff <= p3_ff;
         x4_ff <= x3_ff;
         ok4_ff <= ok3_ff;
         in4_ff <= in3_ff;
         uni_ff <= {1'b0, a_area_ff} + {1'b0, ab3_ff} - {1'b0, in3_ff};
         p5_ff <= p4_ff;
         x5_ff <= x4_ff;
         ok5_ff <= ok4_ff;
         in5_ff <= in4_ff;
         prod_ff <= {{(AREA_W+1){1'b0}}, cfg.threshold} *
                    {{THR_W{1'b0}}, uni_ff};
         if (p5_ff && ok5_ff &&
             {1'b0, in5_ff, {THR_W{1'b0}}} > prod_ff) begin
            sup_ff[x5_ff] <= 1'b1;
         end

         case (state_ff)
            LOAD: begin
               if (q_valid) begin
                  if (cnt_ff < MAXN) cnt_ff <= cnt_ff + 1'b1;
                  else               ovf_ff <= 1'b1;
                  if (q_data.last) begin
                     i_ff     <= '0;
                     state_ff <= RK_I;
                  end
               end
            end
            RK_I: state_ff <= RK_IW;
            RK_IW: begin
               si_ff    <= sc_rd[CLASS_W +: SCORE_W];
               j_ff     <= '0;
               rank_ff  <= '0;
               v1_ff    <= 1'b0;
               state_ff <= RK_SCAN;
            end
            RK_SCAN: begin
               v1_ff <= issue_j;
               jp_ff <= j_ff;
               if (issue_j) j_ff <= j_ff + 1'b1;
               if (v1_ff && (sc_rd[CLASS_W +: SCORE_W] > si_ff ||
                             (sc_rd[CLASS_W +: SCORE_W] == si_ff && jp_ff < i_ff))) begin
                  rank_ff <= rank_ff + 1'b1;
               end
               if (rk_done) begin
                  if (i_ff + 1'b1 == cnt_ff) begin
                     i_ff     <= '0;
                     sup_ff   <= '0;
                     state_ff <= N_I;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= RK_I;
                  end
               end
            end
            N_I: begin
               if (i_ff == cnt_ff)              state_ff <= N_END;
               else if (sup_ff[i_ff[IW-1:0]])   i_ff <= i_ff + 1'b1;
               else                             state_ff <= N_IO;
            end
            N_IO: state_ff <= N_ID;
            N_ID: begin
               a_box_ff  <= box_rd;
               a_sc_ff   <= sc_rd;
               a_area_ff <= area_rd;
               state_ff  <= N_PUSH;
            end
            N_PUSH: begin
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     out_ff      <= pend_ff;
                     out_vld_ff  <= 1'b1;
                     out_last_ff <= 1'b0;
                     out_ovf_ff  <= ovf_ff;
                  end
                  pend_ff     <= {a_box_ff, a_sc_ff};
                  pend_vld_ff <= 1'b1;
                  j_ff        <= i_ff + 1'b1;
                  state_ff    <= N_SCAN;
               end
            end
            N_SCAN: begin
               if (issue_j) j_ff <= j_ff + 1'b1;
               if (sc_done) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= N_I;
               end
            end
            N_END: begin
               if (out_free) begin
                  out_ff      <= pend_ff;
                  out_vld_ff  <= 1'b1;
                  out_last_ff <= 1'b1;
                  out_ovf_ff  <= ovf_ff;
                  pend_vld_ff <= 1'b0;
                  cnt_ff      <= '0;
                  ovf_ff      <= 1'b0;
                  state_ff    <= LOAD;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAXN) else $error("entry count beyond store depth");
   a_scan_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == N_SCAN |-> pend_vld_ff) else $error("scan without a kept entry");
   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      or_we |-> rank_ff < cnt_ff) else $error("rank outside the set");
   a_end_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == N_END |-> pend_vld_ff) else $error("set ends with nothing kept");

endmodule

// File: rtl/greedy_box_nms.sv
// Top level of the greedy box non-maximum suppression block.
// Detections stream in one per cycle while the engine is loading; an input
// stage and a four-entry queue let the next set start arriving while the
// engine still works on the current one. After the item marked tlast, a set
// of stored entries is rank-sorted and then suppressed, both paced by the
// single read port of the entry memories, with suppression also held while
// the output is held off; kept boxes leave in score order through an output
// register, the last one flagged by rsp_tlast.
module greedy_box_nms
   import gbn_pkg::*;
#(
   parameter int unsigned MAX_DETECTIONS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // class, score, left, top, right, bottom edges
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // kept class, score, left, top, right, bottom
   output logic         rsp_tlast,
   output logic         rsp_tuser,   // overflowed
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   cfg_type   cfg_ff;
   logic      f_valid, f_ready, b_valid, b_ready;
   entry_type f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THR_RESET;
         cfg_ff.agnostic  <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_THRESHOLD: cfg_ff.threshold <= csr_wdata;
            CSR_AGNOSTIC:  cfg_ff.agnostic  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   gbn_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data));

   gbn_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data));

   gbn_back #(.MAX_DETECTIONS(MAX_DETECTIONS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid(b_valid), .q_ready(b_ready),
      .q_data(b_data), .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .rsp_tuser);

endmodule

// File: sim/greedy_box_nms_tb.sv
// Self-checking testbench for greedy_box_nms: directed sets, then random clustered sets.
`timescale 1ns / 100ps

module greedy_box_nms_tb;
   import gbn_pkg::*;

   typedef struct packed {
      logic [15:0] bottom;
      logic [15:0] right;
      logic [15:0] top;
      logic [15:0] left;
      logic [15:0] score;
      logic [7:0]  cls;
   } det_type;

   typedef struct packed {
      det_type d;
      logic    run_last;
      logic    ovf;
   } kept_type;

   typedef struct {
      det_type  d;
      bit       last;
      bit       typed;
      kept_type exp;
   } row_type;

   localparam int DEPTH = 64;
   localparam int HOLD_CYCLES = 2000;
   localparam int WATCHDOG = 60000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // class, score, left, top, right, bottom
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;        // class, score, left, top, right, bottom
   logic        rsp_tlast;
   logic        rsp_tuser;        // overflowed
   logic        csr_wen = 1'b0;
   logic        csr_addr = CSR_THRESHOLD;
   logic [15:0] csr_wdata = '0;

   // typed expectation travels alongside the transaction
   logic        row_typed = 1'b0;
   kept_type    row_exp = '0;

   greedy_box_nms dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // suppression predictor state
   det_type     det_store [DEPTH];
   int          det_count = 0;
   bit          det_ovf = 0;
   logic [15:0] cur_thr = THR_RESET;
   bit          cur_agn = 0;
   kept_type    kept_q [$];

   int  errors = 0;
   bit  quiet = 0;
   bit  long_hold = 0;
   int  items_sent = 0;
   int  cx, cy;
   row_type dir_tab [$];

   function automatic longint unsigned span(logic [15:0] lo, logic [15:0] hi);
      return (hi > lo) ? longint'(hi - lo) : 0;
   endfunction

   function automatic bit too_close(det_type a, det_type b);
      longint unsigned x1, y1, x2, y2, inter, uni;
      x1 = 64'((a.left > b.left) ? a.left : b.left);
      y1 = 64'((a.top > b.top) ? a.top : b.top);
      x2 = 64'((a.right < b.right) ? a.right : b.right);
      y2 = 64'((a.bottom < b.bottom) ? a.bottom : b.bottom);
      if (!(x2 > x1 && y2 > y1)) return 0;
      inter = (x2 - x1) * (y2 - y1);
      uni = span(a.left, a.right) * span(a.top, a.bottom)
          + span(b.left, b.right) * span(b.top, b.bottom) - inter;
      return (inter << 16) > longint'(cur_thr) * uni;
   endfunction

   task automatic absorb(det_type d, bit set_end);
      int    ord [DEPTH];
      bit    gone [DEPTH];
      int    key, j, first;
      if (det_count < DEPTH) begin
         det_store[det_count] = d;
         det_count++;
      end else begin
         det_ovf = 1;
      end
      if (!set_end) return;
      for (int i = 0; i < det_count; i++) begin
         key = i;
         j = i;
         while (j > 0 && det_store[ord[j-1]].score < det_store[key].score) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = key;
         gone[i] = 0;
      end
      first = kept_q.size();
      for (int i = 0; i < det_count; i++) begin
         if (gone[i]) continue;
         for (int k = i + 1; k < det_count; k++) begin
            if (gone[k]) continue;
            if (!cur_agn && det_store[ord[i]].cls != det_store[ord[k]].cls) continue;
            if (too_close(det_store[ord[i]], det_store[ord[k]])) gone[k] = 1;
         end
         kept_q.insert(kept_q.size(), '{det_store[ord[i]], 1'b0, det_ovf});
      end
      if (kept_q.size() > first) kept_q[kept_q.size()-1].run_last = 1'b1;
      det_count = 0;
      det_ovf = 0;
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         absorb(det_type'(req_tdata), req_tlast);
         if (row_typed) kept_q[kept_q.size()-1] = row_exp;
      end
   end

   always @(posedge clock) begin
      kept_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{det_type'(rsp_tdata), rsp_tlast, rsp_tuser};
         if (kept_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
         end else begin
            if (got !== kept_q[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h last %b ovf %b, got %h last %b ovf %b",
                           kept_q[0].d, kept_q[0].run_last, kept_q[0].ovf,
                           got.d, got.run_last, got.ovf);
            end
            void'(kept_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no transaction
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen || reset)
         stall_cycles <= 0;
      else if (stall_cycles >= WATCHDOG) begin
         $display("** greedy_box_nms: FAILED **");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // result receiver
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send(det_type d, bit last, bit typed, kept_type exp);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      row_typed  <= typed;
      row_exp    <= exp;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      row_typed  <= 1'b0;
      @(posedge clock);
      wait (kept_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic addr, logic [15:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (addr == CSR_THRESHOLD) cur_thr = data;
      else cur_agn = data[0];
      @(posedge clock);
   endtask

   function automatic logic [15:0] clip(int v);
      return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic det_type mk(int c, int s, int l, int t, int r, int b);
      return '{16'(b), 16'(r), 16'(t), 16'(l), 16'(s), 8'(c)};
   endfunction

   function automatic det_type rand_det();
      det_type d;
      int      w, h, l, t;
      if ($urandom_range(0, 5) == 0) begin
         d = {$urandom, $urandom, 24'($urandom)};
      end else begin
         w = $urandom_range(1, 3000);
         h = $urandom_range(1, 3000);
         l = cx + $urandom_range(0, 800) - 400;
         t = cy + $urandom_range(0, 800) - 400;
         d.cls    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
         d.score  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3) * 16'h4000)
                                                 : 16'($urandom);
         d.left   = clip(l);
         d.top    = clip(t);
         d.right  = clip(l + w);
         d.bottom = clip(t + h);
      end
      return d;
   endfunction

   task automatic send_set(int n);
      cx = $urandom_range(0, 63000);
      cy = $urandom_range(0, 63000);
      for (int i = 0; i < n; i++)
         send(rand_det(), i == n - 1, 1'b0, '0);
   endtask

   task automatic random_sets(int upto);
      while (items_sent < upto)
         send_set(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
   endtask

   initial begin
      kept_type none;
      none = '0;
      // single-entry sets come back unchanged
      dir_tab.insert(dir_tab.size(), '{mk(0, 0, 0, 0, 0, 0), 1, 1,
                     '{mk(0, 0, 0, 0, 0, 0), 1'b1, 1'b0}});
      dir_tab.insert(dir_tab.size(), '{mk(255, 65535, 65535, 65535, 65535, 65535), 1, 1,
                     '{mk(255, 65535, 65535, 65535, 65535, 65535), 1'b1, 1'b0}});
      dir_tab.insert(dir_tab.size(), '{mk(7, 100, 500, 500, 100, 100), 1, 1,
                     '{mk(7, 100, 500, 500, 100, 100), 1'b1, 1'b0}});
      // equal scores, identical boxes: arrival order wins
      dir_tab.insert(dir_tab.size(), '{mk(1, 500, 100, 100, 900, 900), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(1, 500, 100, 100, 900, 900), 1, 0, none});
      // identical boxes of different classes both survive
      dir_tab.insert(dir_tab.size(), '{mk(1, 800, 100, 100, 900, 900), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(2, 900, 100, 100, 900, 900), 1, 0, none});
      // boxes that only touch along an edge
      dir_tab.insert(dir_tab.size(), '{mk(3, 300, 0, 0, 100, 100), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(3, 400, 100, 0, 200, 100), 1, 0, none});
      // non-decreasing arrival scores, partial overlaps and one disjoint box
      dir_tab.insert(dir_tab.size(), '{mk(4, 10, 0, 0, 1000, 1000), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(4, 20, 100, 100, 1100, 1100), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(4, 30, 50, 50, 1050, 1050), 0, 0, none});
      dir_tab.insert(dir_tab.size(), '{mk(4, 30, 5000, 5000, 6000, 6000), 1, 0, none});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send(dir_tab[i].d, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].exp);
      drain();

      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_AGNOSTIC, 16'd1);
      long_hold = 1;
      random_sets(80);
      send_set(DEPTH);
      drain();

      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_AGNOSTIC, 16'd0);
      random_sets(170);
      send_set(DEPTH + 6);
      drain();

      write_csr(CSR_THRESHOLD, 16'($urandom_range(8000, 50000)));
      write_csr(CSR_AGNOSTIC, 16'($urandom_range(0, 1)));
      random_sets(230);
      drain();

      write_csr(CSR_THRESHOLD, THR_RESET);
      write_csr(CSR_AGNOSTIC, 16'd0);
      quiet = 1;
      random_sets(275);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0 && kept_q.size() == 0)
         $display("** greedy_box_nms: PASSED **");
      else
         $display("** greedy_box_nms: FAILED **");
      $finish;
   end

endmodule
